### rtl/base64_codec_stream_assert.svh
// assertion macros shared by the base64 codec stream rtl
`ifndef BASE64_CODEC_STREAM_ASSERT_SVH
`define BASE64_CODEC_STREAM_ASSERT_SVH

// cond holds at an edge, prop holds at the same edge
`define B64CS_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("b64cs assertion failed: same-cycle check");

// cond holds at an edge, prop holds at the next edge
`define B64CS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("b64cs assertion failed: next-cycle check");

`endif

### rtl/b64cs_pkg.sv
// shared types, codes and table functions of the base64 codec stream
`default_nettype none

package b64cs_pkg;

   localparam int JOB_QUEUE_DEPTH = 4;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [7:0] PAD_CHAR     = 8'h3D;
   localparam logic [7:0] PAD_CODE     = 8'h40;
   localparam logic [7:0] INVALID_CODE = 8'h80;
   localparam logic [5:0] SEXTET_MASK  = 6'h3F;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_COUNT = 2'd1,
      STATUS_BAD_PAD   = 2'd2
   } status_type;

   // one accepted word turned into up to four result words
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last;
      logic            bare;
      logic            eom;
      status_type      status;
   } job_type;

   function automatic logic [7:0] alphabet_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

   // 0..63 for alphabet characters, PAD_CODE for '=', INVALID_CODE otherwise
   function automatic logic [7:0] sextet_of(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
         v = 8'd62;
      end else if (c == 8'h2F) begin
         v = 8'd63;
      end else if (c == PAD_CHAR) begin
         v = PAD_CODE;
      end else begin
         v = INVALID_CODE;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

### rtl/b64cs_front.sv
// front end: takes input words, keeps message state and builds result jobs
`default_nettype none

module b64cs_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_write_data,
   input  wire logic              item_accept,
   input  wire logic [7:0]        in_byte,
   input  wire logic              end_of_message,
   output logic                   job_push,
   output b64cs_pkg::job_type     job
);

   logic        mode_ff;
   logic [23:0] acc_ff, acc_in;
   logic [1:0]  fill_ff, fill_in;
   logic [2:0]  pad_ff, pad_in;
   logic [1:0]  vcnt_ff, vcnt_in;
   logic        saw_ff, saw_in;
   logic        fin_ff, fin_in;
   logic        perr_ff, perr_in;

   logic [7:0]  code;
   logic        is_pad;
   logic        is_invalid;
   logic [5:0]  sextet;
   logic [1:0]  enc_fill;
   logic [2:0]  enc_count;
   logic [23:0] enc_acc;
   logic [23:0] dec_acc;
   logic [2:0]  pad_next;
   logic [2:0]  nres;
   b64cs_pkg::status_type status_next;

   assign code       = b64cs_pkg::sextet_of(in_byte);
   assign is_pad     = (code == b64cs_pkg::PAD_CODE);
   assign is_invalid = (code == b64cs_pkg::INVALID_CODE);
   assign sextet     = is_pad ? 6'd0 : code[5:0];
   assign enc_fill   = (fill_ff == 2'd3) ? 2'd0 : fill_ff;
   assign enc_count  = {1'b0, enc_fill} + 3'd1;
   assign dec_acc    = {acc_ff[17:0], sextet};
   assign pad_next   = is_pad ? pad_ff + 3'd1 : pad_ff;

   always_comb begin
      case (enc_fill)
         2'd0:    enc_acc = acc_ff | {in_byte, 16'h0000};
         2'd1:    enc_acc = acc_ff | {8'h00, in_byte, 8'h00};
         default: enc_acc = acc_ff | {16'h0000, in_byte};
      endcase
   end

   always_comb begin
      acc_in      = acc_ff;
      fill_in     = fill_ff;
      pad_in      = pad_ff;
      vcnt_in     = vcnt_ff;
      saw_in      = saw_ff;
      fin_in      = fin_ff;
      perr_in     = perr_ff;
      nres        = 3'd0;
      status_next = b64cs_pkg::STATUS_OK;
      job         = '0;

      if (mode_ff == b64cs_pkg::MODE_ENCODE) begin
         if (enc_count == 3'd3 || end_of_message) begin
            job.data[0] = b64cs_pkg::alphabet_char(enc_acc[23:18] & b64cs_pkg::SEXTET_MASK);
            job.data[1] = b64cs_pkg::alphabet_char(enc_acc[17:12] & b64cs_pkg::SEXTET_MASK);
            job.data[2] = (enc_count > 3'd1) ?
                          b64cs_pkg::alphabet_char(enc_acc[11:6]) : b64cs_pkg::PAD_CHAR;
            job.data[3] = (enc_count > 3'd2) ?
                          b64cs_pkg::alphabet_char(enc_acc[5:0]) : b64cs_pkg::PAD_CHAR;
            nres    = 3'd4;
            acc_in  = '0;
            fill_in = 2'd0;
         end else begin
            acc_in  = enc_acc;
            fill_in = enc_count[1:0];
         end
      end else if (!is_invalid) begin
         saw_in  = 1'b1;
         vcnt_in = vcnt_ff + 2'd1;
         // after a padded block characters only count toward status
         if (!fin_ff) begin
            if (fill_ff == 2'd3) begin
               case (pad_next)
                  3'd0:    nres = 3'd3;
                  3'd1:    nres = 3'd2;
                  3'd2:    nres = 3'd1;
                  default: begin
                     nres    = 3'd0;
                     perr_in = 1'b1;
                  end
               endcase
               job.data[0] = dec_acc[23:16];
               job.data[1] = dec_acc[15:8];
               job.data[2] = dec_acc[7:0];
               fin_in  = (pad_next != 3'd0);
               acc_in  = '0;
               fill_in = 2'd0;
               pad_in  = 3'd0;
            end else begin
               acc_in  = dec_acc;
               fill_in = fill_ff + 2'd1;
               pad_in  = pad_next;
            end
         end
      end

      if (mode_ff == b64cs_pkg::MODE_DECODE) begin
         if (!saw_in || vcnt_in != 2'd0) begin
            status_next = b64cs_pkg::STATUS_BAD_COUNT;
         end else if (perr_in) begin
            status_next = b64cs_pkg::STATUS_BAD_PAD;
         end
      end

      job.eom    = end_of_message;
      job.bare   = end_of_message && (nres == 3'd0);
      job.last   = (nres == 3'd0) ? 2'd0 : 2'(nres - 3'd1);
      job.status = status_next;
      if (job.bare) begin
         job.data = '0;
      end
      job_push = item_accept && ((nres != 3'd0) || end_of_message);

      // message state returns to reset after every message
      if (end_of_message) begin
         acc_in  = '0;
         fill_in = 2'd0;
         pad_in  = 3'd0;
         vcnt_in = 2'd0;
         saw_in  = 1'b0;
         fin_in  = 1'b0;
         perr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= b64cs_pkg::MODE_ENCODE;
         acc_ff  <= '0;
         fill_ff <= 2'd0;
         pad_ff  <= 3'd0;
         vcnt_ff <= 2'd0;
         saw_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         perr_ff <= 1'b0;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
         acc_ff  <= '0;
         fill_ff <= 2'd0;
         pad_ff  <= 3'd0;
         vcnt_ff <= 2'd0;
         saw_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         perr_ff <= 1'b0;
      end else if (item_accept) begin
         acc_ff  <= acc_in;
         fill_ff <= fill_in;
         pad_ff  <= pad_in;
         vcnt_ff <= vcnt_in;
         saw_ff  <= saw_in;
         fin_ff  <= fin_in;
         perr_ff <= perr_in;
      end
   end

endmodule

`default_nettype wire

### rtl/b64cs_job_queue.sv
// short job queue between the front end and the result sequencer
`default_nettype none
`include "base64_codec_stream_assert.svh"

module b64cs_job_queue #(
   parameter int DEPTH = b64cs_pkg::JOB_QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire b64cs_pkg::job_type job_in,
   output logic                    full,
   input  wire logic               pop,
   output b64cs_pkg::job_type      job_out,
   output logic                    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64cs_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign job_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

   `B64CS_ASSERT_IMPLIES(q_no_push_when_full, clock, reset, push, !full)
   `B64CS_ASSERT_IMPLIES(q_no_pop_when_empty, clock, reset, pop, !empty)
   `B64CS_ASSERT_NEXT(q_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))
   `B64CS_ASSERT_IMPLIES(q_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

### rtl/b64cs_back.sv
// back end: walks the head job and presents its result words one at a time
`default_nettype none
`include "base64_codec_stream_assert.svh"

module b64cs_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire b64cs_pkg::job_type head,
   input  wire logic               head_empty,
   output logic                    head_done,
   input  wire logic               pop,
   output logic [7:0]              out_byte,
   output logic                    byte_valid,
   output logic                    end_of_results,
   output logic [1:0]              status
);

   logic [1:0] idx_ff, idx_in;
   logic       last_word;
   logic       take;

   assign last_word      = (idx_ff == head.last);
   assign take           = pop && !head_empty;
   assign head_done      = take && last_word;
   assign out_byte       = head.data[idx_ff];
   assign byte_valid     = !head.bare;
   assign end_of_results = head.eom && last_word;
   assign status         = end_of_results ? head.status : b64cs_pkg::STATUS_OK;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last_word ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   `B64CS_ASSERT_IMPLIES(bk_idx_needs_job, clock, reset, idx_ff != 2'd0, !head_empty)
   `B64CS_ASSERT_IMPLIES(bk_idx_in_range, clock, reset, !head_empty, idx_ff <= head.last)

endmodule

`default_nettype wire

### rtl/base64_codec_stream.sv
// Streaming base64 codec (standard alphabet, '=' padding). csr_write_data selects encode (0) or
// decode (1); a write also drops any message in progress, so write it only while idle. Input
// words are taken at one per cycle while full is low. Each word is classified in the same
// cycle and turned into a job of up to four result words that waits in a short queue
// (QUEUE_DEPTH jobs); the result side drains it at one word per cycle while pop is high.
// Encoding gives four characters per three bytes, so for a steady encode stream the result
// side sets the sustained rate; decoding gives up to three bytes per four characters. Each
// job is written into the queue registers before its first result word is shown. The
// last word of each message carries end_of_results and the status; a message end with no
// data gives a bare end marker with byte_valid low.
`default_nettype none

module base64_codec_stream #(
   parameter int QUEUE_DEPTH = b64cs_pkg::JOB_QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_message,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_end_of_results,
   output logic [1:0]      rsp_status
);

   logic               item_accept;
   logic               job_push;
   logic               job_pop;
   b64cs_pkg::job_type new_job;
   b64cs_pkg::job_type head_job;

   assign item_accept = push && !full;

   b64cs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_accept      (item_accept),
      .in_byte          (req_in_byte),
      .end_of_message   (req_end_of_message),
      .job_push         (job_push),
      .job              (new_job)
   );

   b64cs_job_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .job_in  (new_job),
      .full    (full),
      .pop     (job_pop),
      .job_out (head_job),
      .empty   (empty)
   );

   b64cs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head_job),
      .head_empty     (empty),
      .head_done      (job_pop),
      .pop            (pop),
      .out_byte       (rsp_out_byte),
      .byte_valid     (rsp_byte_valid),
      .end_of_results (rsp_end_of_results),
      .status         (rsp_status)
   );

endmodule

`default_nettype wire

### dv/base64_codec_stream_checker.sv
// checker for the base64 codec stream: predicts result words from accepted input words
module base64_codec_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       push,
   input  logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_message,
   input  logic       empty,
   input  logic       pop,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_byte_valid,
   input  logic       rsp_end_of_results,
   input  logic [1:0] rsp_status,
   output int         words_pending,
   output int         mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]            out_byte;
      logic                  byte_valid;
      logic                  end_of_results;
      b64cs_pkg::status_type status;
   } codec_word_type;

   string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic [7:0]     sextet_lut [0:255];
   codec_word_type expected_words [$];
   int             mismatches = 0;

   // message state of the codec
   logic        mode_q;
   logic [23:0] acc;
   logic [1:0]  grp_fill;
   logic [2:0]  pad_cnt;
   logic [1:0]  char_cnt;
   logic        saw_char;
   logic        blk_done;
   logic        pad_err;

   initial begin
      for (int i = 0; i < 256; i++) sextet_lut[i] = b64cs_pkg::INVALID_CODE;
      for (int i = 0; i < 64; i++) sextet_lut[alphabet[i]] = i[7:0];
      sextet_lut[b64cs_pkg::PAD_CHAR] = b64cs_pkg::PAD_CODE;
   end

   function automatic void clear_message();
      acc      = '0;
      grp_fill = '0;
      pad_cnt  = '0;
      char_cnt = '0;
      saw_char = 1'b0;
      blk_done = 1'b0;
      pad_err  = 1'b0;
   endfunction

   function automatic codec_word_type data_word(input logic [7:0] b);
      codec_word_type w;
      w.out_byte       = b;
      w.byte_valid     = 1'b1;
      w.end_of_results = 1'b0;
      w.status         = b64cs_pkg::STATUS_OK;
      return w;
   endfunction

   task automatic predict_codec_words(input logic [7:0] b, input logic eom);
      codec_word_type        w [4];
      int                    n;
      int                    f;
      int                    keep;
      logic [7:0]            v;
      b64cs_pkg::status_type st;
      n  = 0;
      st = b64cs_pkg::STATUS_OK;
      if (mode_q == b64cs_pkg::MODE_ENCODE) begin
         f   = (grp_fill == 2'd3) ? 0 : int'(grp_fill);
         acc = acc | ({16'd0, b} << (16 - 8 * f));
         f   = f + 1;
         if (f == 3 || eom) begin
            w[0] = data_word(alphabet[acc[23:18]]);
            w[1] = data_word(alphabet[acc[17:12]]);
            w[2] = data_word((f > 1) ? alphabet[acc[11:6]] : b64cs_pkg::PAD_CHAR);
            w[3] = data_word((f > 2) ? alphabet[acc[5:0]] : b64cs_pkg::PAD_CHAR);
            n        = 4;
            acc      = '0;
            grp_fill = '0;
         end else begin
            grp_fill = f[1:0];
         end
      end else begin
         v = sextet_lut[b];
         if (v != b64cs_pkg::INVALID_CODE) begin
            saw_char = 1'b1;
            char_cnt = char_cnt + 2'd1;
            // after a padded block characters only count toward the status
            if (!blk_done) begin
               if (v == b64cs_pkg::PAD_CODE) begin
                  pad_cnt = pad_cnt + 3'd1;
                  v       = '0;
               end
               acc = {acc[17:0], v[5:0]};
               if (grp_fill == 2'd3) begin
                  case (pad_cnt)
                     3'd0: keep = 3;
                     3'd1: keep = 2;
                     3'd2: keep = 1;
                     default: keep = 0;
                  endcase
                  if (keep == 0) pad_err = 1'b1;
                  if (keep >= 1) begin w[n] = data_word(acc[23:16]); n++; end
                  if (keep >= 2) begin w[n] = data_word(acc[15:8]); n++; end
                  if (keep >= 3) begin w[n] = data_word(acc[7:0]); n++; end
                  if (pad_cnt != 3'd0) blk_done = 1'b1;
                  acc      = '0;
                  grp_fill = '0;
                  pad_cnt  = '0;
               end else begin
                  grp_fill = grp_fill + 2'd1;
               end
            end
         end
         if (!saw_char || char_cnt != 2'd0) st = b64cs_pkg::STATUS_BAD_COUNT;
         else if (pad_err) st = b64cs_pkg::STATUS_BAD_PAD;
      end
      if (eom) begin
         if (n == 0) begin
            w[0] = data_word(8'h00);
            w[0].byte_valid = 1'b0;
            n = 1;
         end
         w[n-1].end_of_results = 1'b1;
         w[n-1].status         = st;
         clear_message();
      end
      for (int i = 0; i < n; i++) expected_words.push_back(w[i]);
   endtask

   task automatic check_codec_word();
      codec_word_type w;
      if (expected_words.size() == 0) begin
         $error("result word 0x%02h arrived with nothing expected", rsp_out_byte);
         mismatches++;
      end else begin
         w = expected_words.pop_front();
         if (rsp_out_byte !== w.out_byte) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", w.out_byte, rsp_out_byte);
            mismatches++;
         end
         if (rsp_byte_valid !== w.byte_valid) begin
            $error("byte_valid: expected %0d, actual %0d", w.byte_valid, rsp_byte_valid);
            mismatches++;
         end
         if (rsp_end_of_results !== w.end_of_results) begin
            $error("end_of_results: expected %0d, actual %0d",
                   w.end_of_results, rsp_end_of_results);
            mismatches++;
         end
         if (rsp_status !== w.status) begin
            $error("status: expected %0d, actual %0d", w.status, rsp_status);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_q = b64cs_pkg::MODE_ENCODE;
         clear_message();
         expected_words.delete();
      end else begin
         if (csr_write_enable) begin
            mode_q = csr_write_data;
            clear_message();
         end
         if (push && !full) predict_codec_words(req_in_byte, req_end_of_message);
         if (pop && !empty) check_codec_word();
      end
      words_pending  <= expected_words.size();
      mismatch_count <= mismatches;
   end

endmodule

### dv/tb_base64_codec_stream.sv
// top of the base64 codec stream testbench: clock, reset, stimulus and verdict
module tb_base64_codec_stream;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_WORDS  = 80;

   string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       csr_write_enable   = 1'b0;
   logic       csr_write_data     = 1'b0;
   logic       push               = 1'b0;
   logic       full;
   logic [7:0] req_in_byte        = 8'h00;
   logic       req_end_of_message = 1'b0;
   logic       empty;
   logic       pop                = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_end_of_results;
   logic [1:0] rsp_status;

   int         words_pending;
   int         mismatch_count;

   logic [7:0] msg_buf [$];
   int         words_sent    = 0;
   int         messages_sent = 0;
   int         words_out     = 0;
   int         idle_cycles   = 0;
   int         send_quiet    = 0;
   int         recv_quiet    = 0;
   int         pop_gap;
   int         pop_hold      = 0;

   base64_codec_stream u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .push               (push),
      .full               (full),
      .req_in_byte        (req_in_byte),
      .req_end_of_message (req_end_of_message),
      .empty              (empty),
      .pop                (pop),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_end_of_results (rsp_end_of_results),
      .rsp_status         (rsp_status)
   );

   base64_codec_stream_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .push               (push),
      .full               (full),
      .req_in_byte        (req_in_byte),
      .req_end_of_message (req_end_of_message),
      .empty              (empty),
      .pop                (pop),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_end_of_results (rsp_end_of_results),
      .rsp_status         (rsp_status),
      .words_pending      (words_pending),
      .mismatch_count     (mismatch_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly random gaps, now and then a stretch with none
   function automatic int draw_gap(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         quiet_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic logic [7:0] rand_char();
      return alphabet[$urandom_range(0, 63)];
   endfunction

   // result side: a random stall, possibly none, before each word
   always @(posedge clock) begin
      if (reset) begin
         pop      <= 1'b0;
         pop_hold <= 0;
      end else if (pop && !empty) begin
         pop_gap = draw_gap(recv_quiet);
         pop      <= (pop_gap == 0);
         pop_hold <= (pop_gap == 0) ? 0 : pop_gap - 1;
      end else if (!pop) begin
         if (pop_hold == 0) pop <= 1'b1;
         else pop_hold <= pop_hold - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (pop && !empty) words_out <= words_out + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [7:0] b, input logic eom);
      int gap;
      gap = draw_gap(send_quiet);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push               <= 1'b1;
      req_in_byte        <= b;
      req_end_of_message <= eom;
      do @(posedge clock); while (full);
      words_sent++;
      if (eom) messages_sent++;
   endtask

   task automatic send_buffer();
      for (int i = 0; i < msg_buf.size(); i++) send_word(msg_buf[i], i == msg_buf.size() - 1);
   endtask

   task automatic send_text(input string s);
      msg_buf.delete();
      for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
      send_buffer();
   endtask

   // let every expected word drain and the pipeline go quiet
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic gen_encode_message();
      int len;
      msg_buf.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 10);
      repeat (len) begin
         if ($urandom_range(0, 4) == 0) msg_buf.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
         else msg_buf.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic gen_decode_message();
      int groups;
      int tail;
      int kind;
      int pos;
      msg_buf.delete();
      groups = $urandom_range(0, 3);
      tail   = $urandom_range(0, 2);
      repeat (groups * 4) msg_buf.push_back(rand_char());
      repeat (4 - tail) msg_buf.push_back(rand_char());
      repeat (tail) msg_buf.push_back(b64cs_pkg::PAD_CHAR);
      if ($urandom_range(0, 9) == 0) begin
         pos = $urandom_range(0, msg_buf.size());
         msg_buf.insert(pos, 8'($urandom_range(0, 255)));
      end
      kind = $urandom_range(0, 99);
      if (kind >= 70) begin
         case (kind % 5)
            0: msg_buf.delete($urandom_range(0, msg_buf.size() - 1));
            // trailing characters, after a padded block when there is one
            1: repeat ($urandom_range(1, 5))
                  msg_buf.push_back(($urandom_range(0, 4) == 0) ?
                                    b64cs_pkg::PAD_CHAR : rand_char());
            // three or four pads in the last block
            2: begin
               pos = msg_buf.size() - 4;
               for (int i = 0; i < 4; i++)
                  if (i > 0 || $urandom_range(0, 1)) msg_buf[pos + i] = b64cs_pkg::PAD_CHAR;
            end
            3: msg_buf[$urandom_range(0, msg_buf.size() - 1)] = b64cs_pkg::PAD_CHAR;
            default: begin
               msg_buf.delete();
               repeat ($urandom_range(1, 8)) msg_buf.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end
      if (msg_buf.size() == 0) msg_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int target;
      logic m;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_mode(b64cs_pkg::MODE_ENCODE);
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b0);
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h80, 1'b1);
      // leave a group open; the mode write drops it
      send_word(8'h7F, 1'b0);
      settle();
      write_mode(b64cs_pkg::MODE_DECODE);
      send_text("Tm=u");
      send_text("=A==");
      send_text("TQ==Zg");
      send_text("*");
      send_text("TW~");
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         m = (phase == 1 || phase == 3 || phase == 4) ?
             b64cs_pkg::MODE_DECODE : b64cs_pkg::MODE_ENCODE;
         write_mode(m);
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) begin
            if (m == b64cs_pkg::MODE_ENCODE) gen_encode_message();
            else gen_decode_message();
            send_buffer();
         end
         settle();
      end

      repeat (8) @(posedge clock);
      $display("sent %0d words in %0d messages through encode and decode settings",
               words_sent, messages_sent);
      $display("checked %0d result words, %0d mismatches", words_out, mismatch_count);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
